// File: design/huffman_code_builder_assert.svh
// Assertion macros for huffman_code_builder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define HCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Invariant checked in the cycle after a trigger.
`define HCB_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) trig |=> prop) \
        else $error(msg);

`endif

// File: design/hcb_pkg.sv
// Shared constants, payload structs and state codes for the Huffman code builder.
// No dependencies.
package hcb_pkg;

    localparam int SYMBOLS      = 16;
    localparam int MAX_CODE_LEN = 15;
    localparam int NODES        = 2 * SYMBOLS - 1;

    localparam int KEY_W   = 8;
    localparam int IW_W    = 16;
    localparam int CODE_W  = 15;
    localparam int LEN_W   = 4;
    localparam int W_W     = IW_W + $clog2(SYMBOLS);
    localparam int ID_W    = $clog2(NODES);
    localparam int FILL_W  = $clog2(NODES + 1);
    localparam int LOAD_W  = $clog2(SYMBOLS + 1);
    localparam int MRG_W   = $clog2(SYMBOLS);
    localparam int SP_W    = $clog2(SYMBOLS + 1);
    localparam int SIDX_W  = $clog2(SYMBOLS);

    typedef struct packed {
        logic [KEY_W-1:0] symbol_key;
        logic [IW_W-1:0]  symbol_weight;
        logic             set_last;
    } t_sym_in;

    typedef struct packed {
        logic [KEY_W-1:0]  code_key;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              code_last;
    } t_code_out;

    // one queue slot: node weight and node id
    typedef struct packed {
        logic [W_W-1:0]  w;
        logic [ID_W-1:0] id;
    } t_entry;

    typedef enum logic [1:0] {
        Q_HOLD,
        Q_INSERT,
        Q_SHIFT
    } t_qmode;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_POPA,
        ST_POPB,
        ST_MERGE,
        ST_WALK
    } t_state;

endpackage

// File: design/hcb_cell.sv
// One slot of the sorted node queue.
// Depends on hcb_pkg.
module hcb_cell import hcb_pkg::*; (
    input  logic   i_clk,
    input  t_qmode i_mode,
    input  logic   i_live,
    input  t_entry i_new,
    input  t_entry i_prev,
    input  logic   i_prev_lt,
    input  t_entry i_next,
    output t_entry o_entry,
    output logic   o_lt
);

    t_entry r_entry;
    t_entry n_entry;

    // strictly lighter slots stay put; the new entry lands before equal weights
    assign o_lt    = i_live && (r_entry.w < i_new.w);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_mode)
            Q_INSERT: begin
                if (!o_lt) begin
                    n_entry = i_prev_lt ? i_new : i_prev;
                end
            end
            Q_SHIFT: n_entry = i_next;
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: design/hcb_queue.sv
// Weight-sorted node queue built as a chain of hcb_cell slots.
// Depends on hcb_pkg and hcb_cell.
module hcb_queue import hcb_pkg::*; (
    input  logic              i_clk,
    input  t_qmode            i_mode,
    input  logic [FILL_W-1:0] i_fill,
    input  t_entry            i_new,
    output t_entry            o_head
);

    t_entry s_entry [NODES];
    logic   s_lt    [NODES];

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        t_entry s_prev;
        t_entry s_next;
        logic   s_prev_lt;

        if (g == 0) begin : g_first
            assign s_prev    = i_new;
            assign s_prev_lt = 1'b1;
        end else begin : g_mid
            assign s_prev    = s_entry[g-1];
            assign s_prev_lt = s_lt[g-1];
        end

        if (g == NODES - 1) begin : g_tail
            assign s_next = s_entry[g];
        end else begin : g_body
            assign s_next = s_entry[g+1];
        end

        hcb_cell u_cell (
            .i_clk     (i_clk),
            .i_mode    (i_mode),
            .i_live    (FILL_W'(g) < i_fill),
            .i_new     (i_new),
            .i_prev    (s_prev),
            .i_prev_lt (s_prev_lt),
            .i_next    (s_next),
            .o_entry   (s_entry[g]),
            .o_lt      (s_lt[g])
        );
    end

    assign o_head = s_entry[0];

endmodule

// File: design/huffman_code_builder.sv
// Huffman code builder top level: load, merge sequencer and tree walk.
// Depends on hcb_pkg, hcb_queue (hcb_cell) and huffman_code_builder_assert.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_sym_in)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_code_out)
//
// Loading: one pair per cycle, inserted straight into the chain of queue slots.
// Build: each merge pops the left node, pops the right node, then inserts their
//   sum; the walk then visits each tree node, pushing the children of internal
//   nodes and emitting a code at each leaf, and a final step returns to loading.
// Reset clears the control counters and FSM; queue, link and stack contents
//   carry no reset.
// A stalled result holds the walk on the next leaf; o_in_stall is high for the
//   whole build and walk.
`include "huffman_code_builder_assert.svh"

module huffman_code_builder import hcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_sym_in   i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_code_out o_out_data
);

    t_state r_state;
    t_state n_state;

    logic [FILL_W-1:0] r_fill;
    logic [LOAD_W-1:0] r_loaded;
    logic [MRG_W-1:0]  r_merge;
    logic [SP_W-1:0]   r_sp;

    logic [KEY_W-1:0]  r_keys  [SYMBOLS];
    logic [ID_W-1:0]   r_left  [SYMBOLS-1];
    logic [ID_W-1:0]   r_right [SYMBOLS-1];

    // walk stack: node id, partial code, depth
    logic [ID_W-1:0]   r_stk_id   [SYMBOLS];
    logic [CODE_W-1:0] r_stk_code [SYMBOLS];
    logic [LEN_W-1:0]  r_stk_len  [SYMBOLS];

    t_entry    r_a;
    t_entry    r_sum;
    t_code_out r_out;
    logic      r_ovalid;

    // queue control
    t_qmode q_mode;
    t_entry q_new;
    t_entry q_head;

    logic              s_accept;
    logic              s_room;
    logic [LOAD_W-1:0] s_loaded_nx;
    logic              s_out_free;
    logic [SIDX_W-1:0] s_top;
    logic [ID_W-1:0]   s_top_id;
    logic              s_top_int;
    logic [MRG_W-1:0]  s_top_m;
    logic [CODE_W-1:0] s_code_sh;
    logic [LEN_W-1:0]  s_len_nx;
    logic              s_emit;
    logic              s_walk_wait;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign s_accept    = i_in_valid && !o_in_stall;
    assign s_room      = (r_loaded < LOAD_W'(SYMBOLS));
    assign s_loaded_nx = r_loaded + LOAD_W'(s_room);
    assign s_out_free  = !r_ovalid || !i_out_stall;

    // top of stack and the derived child values
    assign s_top     = r_sp[SIDX_W-1:0] - SIDX_W'(1);
    assign s_top_id  = r_stk_id[s_top];
    assign s_top_int = (s_top_id >= ID_W'(SYMBOLS));
    assign s_top_m   = MRG_W'(s_top_id - ID_W'(SYMBOLS));
    assign s_code_sh = {r_stk_code[s_top][CODE_W-2:0], 1'b0};
    assign s_len_nx  = (r_stk_len[s_top] == LEN_W'(MAX_CODE_LEN)) ?
                       r_stk_len[s_top] : r_stk_len[s_top] + LEN_W'(1);
    assign s_emit    = (r_state == ST_WALK) && (r_sp != '0) && !s_top_int && s_out_free;
    // leaf on top but the result register is still blocked
    assign s_walk_wait = (r_state == ST_WALK) && (r_sp != '0) && !s_top_int && !s_out_free;

    hcb_queue u_queue (
        .i_clk  (i_clk),
        .i_mode (q_mode),
        .i_fill (r_fill),
        .i_new  (q_new),
        .o_head (q_head)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (s_accept && i_in_data.set_last && (s_loaded_nx >= LOAD_W'(2))) begin
                    n_state = ST_POPA;
                end
            end
            ST_POPA:  n_state = (r_fill == FILL_W'(1)) ? ST_WALK : ST_POPB;
            ST_POPB:  n_state = ST_MERGE;
            ST_MERGE: n_state = ST_POPA;
            ST_WALK: begin
                if (r_sp == '0) begin
                    n_state = ST_LOAD;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    // queue operation per state
    always_comb begin
        q_mode = Q_HOLD;
        q_new  = r_sum;
        case (r_state)
            ST_LOAD: begin
                q_new = '{w: W_W'(i_in_data.symbol_weight), id: ID_W'(r_loaded)};
                if (s_accept && s_room) begin
                    q_mode = Q_INSERT;
                end
            end
            ST_POPA: begin
                if (r_fill != FILL_W'(1)) begin
                    q_mode = Q_SHIFT;
                end
            end
            ST_POPB:  q_mode = Q_SHIFT;
            ST_MERGE: q_mode = Q_INSERT;
            default:  q_mode = Q_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_fill   <= '0;
            r_loaded <= '0;
            r_merge  <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (i_in_data.set_last && (s_loaded_nx < LOAD_W'(2))) begin
                            r_fill   <= '0;
                            r_loaded <= '0;
                        end else if (s_room) begin
                            r_fill   <= r_fill + FILL_W'(1);
                            r_loaded <= r_loaded + LOAD_W'(1);
                        end
                    end
                end
                ST_POPA: begin
                    if (r_fill == FILL_W'(1)) begin
                        r_sp <= SP_W'(1);
                    end else begin
                        r_fill <= r_fill - FILL_W'(1);
                    end
                end
                ST_POPB: r_fill <= r_fill - FILL_W'(1);
                ST_MERGE: begin
                    r_fill  <= r_fill + FILL_W'(1);
                    r_merge <= r_merge + MRG_W'(1);
                end
                ST_WALK: begin
                    if (r_sp == '0) begin
                        r_fill   <= '0;
                        r_loaded <= '0;
                        r_merge  <= '0;
                    end else if (s_top_int) begin
                        r_sp <= r_sp + SP_W'(1);
                    end else if (s_out_free) begin
                        r_sp <= r_sp - SP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // payload: keys, links, stack, result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && s_accept && s_room) begin
            r_keys[r_loaded[SIDX_W-1:0]] <= i_in_data.symbol_key;
        end
        if (r_state == ST_POPA) begin
            r_a <= q_head;
            if (r_fill == FILL_W'(1)) begin
                r_stk_id[0]   <= q_head.id;
                r_stk_code[0] <= '0;
                r_stk_len[0]  <= '0;
            end
        end
        if (r_state == ST_POPB) begin
            r_left[r_merge]  <= r_a.id;
            r_right[r_merge] <= q_head.id;
            r_sum <= '{w: r_a.w + q_head.w, id: ID_W'(SYMBOLS) + ID_W'(r_merge)};
        end
        if (r_state == ST_WALK && r_sp != '0 && s_top_int) begin
            // left child replaces the parent, right child goes on top
            r_stk_id[s_top]               <= r_left[s_top_m];
            r_stk_code[s_top]             <= s_code_sh;
            r_stk_len[s_top]              <= s_len_nx;
            r_stk_id[r_sp[SIDX_W-1:0]]    <= r_right[s_top_m];
            r_stk_code[r_sp[SIDX_W-1:0]]  <= s_code_sh | CODE_W'(1);
            r_stk_len[r_sp[SIDX_W-1:0]]   <= s_len_nx;
        end
        if (s_emit) begin
            r_out.code_key    <= r_keys[s_top_id[SIDX_W-1:0]];
            r_out.code_bits   <= r_stk_code[s_top];
            r_out.code_length <= r_stk_len[s_top];
            r_out.code_last   <= (r_sp == SP_W'(1));
        end
    end

    `HCB_ASSERT(a_fill_cap, r_fill <= FILL_W'(NODES), "queue fill beyond capacity")
    `HCB_ASSERT(a_sp_cap, r_sp <= SP_W'(SYMBOLS), "walk stack beyond capacity")
    `HCB_ASSERT_NEXT(a_walk_hold, s_walk_wait, $stable(r_sp), "walk moved while result blocked")

endmodule

// File: test/huffman_code_builder_test.sv
// Self-checking testbench for the Huffman code builder: drives symbol sets and
// checks every emitted code against a built-in tree construction.
// Depends on hcb_pkg and the huffman_code_builder RTL.
`timescale 1ns / 1ps

module huffman_code_builder_test;
    import hcb_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_sym_in   i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_code_out o_out_data;

    huffman_code_builder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Stimulus waiting to be driven, and codes waiting to be seen
    t_sym_in   pending_syms[$];
    t_code_out expected_codes[$];
    int        error_count;
    int        sets_sent;
    int        codes_seen;

    // Predictor state: the current set as loaded so far
    logic [KEY_W-1:0] set_keys[SYMBOLS];
    logic [W_W-1:0]   set_weights[NODES];
    int               set_count;

    // Build the tree for the loaded set and queue its codes in walk order.
    task automatic predict_codes();
        int               order[$];
        int               lefts[SYMBOLS];
        int               rights[SYMBOLS];
        int               merges;
        int               a;
        int               b;
        int               m;
        int               pos;
        int               stk_node[$];
        logic [63:0]      stk_code[$];
        int               stk_len[$];
        int               nd;
        int               len;
        logic [63:0]      code;
        t_code_out        res;
        int               first_idx;
        int               i;
        merges = 0;
        first_idx = expected_codes.size();
        // sorted insertion: new entry goes before equal weights
        for (i = 0; i < set_count; i++) begin
            pos = 0;
            while (pos < order.size() && set_weights[order[pos]] < set_weights[i])
                pos++;
            order.insert(pos, i);
        end
        while (order.size() > 1) begin
            a = order.pop_front();
            b = order.pop_front();
            m = SYMBOLS + merges;
            set_weights[m] = set_weights[a] + set_weights[b];
            lefts[merges] = a;
            rights[merges] = b;
            merges++;
            pos = 0;
            while (pos < order.size() && set_weights[order[pos]] < set_weights[m])
                pos++;
            order.insert(pos, m);
        end
        // walk right subtree first (left pushed first, popped last)
        stk_node.push_back(order[0]);
        stk_code.push_back('0);
        stk_len.push_back(0);
        while (stk_node.size() > 0) begin
            nd = stk_node.pop_back();
            code = stk_code.pop_back();
            len = stk_len.pop_back();
            if (nd >= SYMBOLS) begin
                stk_node.push_back(lefts[nd - SYMBOLS]);
                stk_code.push_back(code << 1);
                stk_len.push_back(len + 1);
                stk_node.push_back(rights[nd - SYMBOLS]);
                stk_code.push_back((code << 1) | 64'd1);
                stk_len.push_back(len + 1);
            end else begin
                res.code_key    = set_keys[nd];
                res.code_bits   = code[CODE_W-1:0];
                res.code_length = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(len);
                res.code_last   = 1'b0;
                expected_codes.push_back(res);
            end
        end
        if (expected_codes.size() > first_idx)
            expected_codes[expected_codes.size() - 1].code_last = 1'b1;
    endtask

    // Model one accepted transfer on the input channel.
    task automatic absorb_symbol(input t_sym_in s);
        if (set_count < SYMBOLS) begin
            set_keys[set_count]    = s.symbol_key;
            set_weights[set_count] = W_W'(s.symbol_weight);
            set_count++;
        end
        if (s.set_last) begin
            if (set_count >= 2)
                predict_codes();
            set_count = 0;
            sets_sent++;
        end
    endtask

    // Queue one set; the size may exceed SYMBOLS to exercise the overflow drop.
    task automatic queue_set(input int n, input int wmode);
        t_sym_in s;
        int      i;
        for (i = 0; i < n; i++) begin
            s.symbol_key = 8'($urandom);
            case (wmode)
                0: s.symbol_weight = 16'($urandom);
                1: s.symbol_weight = 16'($urandom_range(0, 3));    // many ties
                2: s.symbol_weight = 16'hFFFF;
                3: s.symbol_weight = 16'(1 << (i % 16));             // skewed, deep tree
                default: s.symbol_weight = 16'($urandom_range(0, 20));
            endcase
            s.set_last = (i == n - 1);
            pending_syms.push_back(s);
        end
    endtask

    // Driver: one item at a time, with a randomly drawn idle gap, or none, before each.
    int drive_gap;
    int gap_draw;
    always @(posedge i_clk) begin
        gap_draw = $urandom_range(0, 3);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drive_gap  <= gap_draw;
        end else if (i_in_valid && !o_in_stall) begin
            // transfer taken; drop valid or present the next item straight away
            absorb_symbol(i_in_data);
            void'(pending_syms.pop_front());
            if (gap_draw == 0 && pending_syms.size() > 0) begin
                i_in_data <= pending_syms[0];
            end else begin
                i_in_valid <= 1'b0;
                drive_gap  <= (gap_draw > 0) ? gap_draw - 1 : 0;
            end
        end else if (!i_in_valid && pending_syms.size() > 0) begin
            if (drive_gap == 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_syms[0];
            end else begin
                drive_gap <= drive_gap - 1;
            end
        end
    end

    // Monitor: randomly drawn stall, or none, after each result; compare with the oldest expectation.
    int stall_left;
    int stall_draw;
    always @(posedge i_clk) begin
        stall_draw = $urandom_range(0, 3);
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    $error("unexpected code: key %0d bits %0h len %0d",
                           o_out_data.code_key, o_out_data.code_bits,
                           o_out_data.code_length);
                    error_count++;
                end else begin
                    t_code_out exp_c;
                    exp_c = expected_codes.pop_front();
                    if (exp_c.code_key !== o_out_data.code_key) begin
                        $error("code_key: expected %0d, got %0d",
                               exp_c.code_key, o_out_data.code_key);
                        error_count++;
                    end
                    if (exp_c.code_bits !== o_out_data.code_bits) begin
                        $error("code_bits: expected %0h, got %0h",
                               exp_c.code_bits, o_out_data.code_bits);
                        error_count++;
                    end
                    if (exp_c.code_length !== o_out_data.code_length) begin
                        $error("code_length: expected %0d, got %0d",
                               exp_c.code_length, o_out_data.code_length);
                        error_count++;
                    end
                    if (exp_c.code_last !== o_out_data.code_last) begin
                        $error("code_last: expected %0d, got %0d",
                               exp_c.code_last, o_out_data.code_last);
                        error_count++;
                    end
                end
                stall_left  <= (stall_draw > 0) ? stall_draw - 1 : 0;
                i_out_stall <= (stall_draw > 0);
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_sym_in s;
        int      total;
        int      sz;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        error_count = 0;
        sets_sent   = 0;
        codes_seen  = 0;
        set_count   = 0;

        // Directed: single-symbol set, two symbols, extremes of key and weight
        s = '{symbol_key: 8'hFF, symbol_weight: 16'hFFFF, set_last: 1'b1};
        pending_syms.push_back(s);
        s = '{symbol_key: 8'h00, symbol_weight: 16'h0000, set_last: 1'b0};
        pending_syms.push_back(s);
        s = '{symbol_key: 8'hFF, symbol_weight: 16'hFFFF, set_last: 1'b1};
        pending_syms.push_back(s);
        queue_set(4, 2);       // all weights equal and maximal
        queue_set(SYMBOLS, 3); // skewed: deepest codes
        // overflow: set_last on a dropped pair still starts the build
        queue_set(SYMBOLS + 2, 1);

        total = pending_syms.size();
        while (total < 480) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, SYMBOLS + 3)
                                              : $urandom_range(2, SYMBOLS);
            queue_set(sz, $urandom_range(0, 4));
            total += sz;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_syms.size() == 0);
        wait (expected_codes.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d sets, %0d codes checked (ties, overflow, single symbol)",
                 sets_sent, codes_seen);
        if (error_count == 0 && expected_codes.size() == 0)
            $display("huffman_code_builder_test: done, clean");
        else
            $display("huffman_code_builder_test: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest run of about 480 items with stalls
    initial begin
        #2000000;
        $display("huffman_code_builder_test: done, errors");
        $finish;
    end

endmodule
